@@ rtl/core/dbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants of the dirty block detector.
// ----------------------------------------------------------------------------
package dbd_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IDX_W      = 8;
    localparam int PIX_W      = 32;
    localparam int BS_W       = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 12'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 12'd1024;
    localparam logic [BS_W-1:0]       RST_BLOCK_SIZE   = 9'd16;

    localparam logic [BS_W-1:0] BS_MIN = 9'd8;
    localparam logic [BS_W-1:0] BS_MAX = 9'd256;

    typedef struct packed {
        logic             report;
        logic             last_block;
        logic [IDX_W-1:0] block_col;
        logic [IDX_W-1:0] block_row;
        logic             differs;
    } scan_t;

endpackage
`default_nettype wire

@@ rtl/core/dirty_block_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dirty_block_detector
// Per-block change detection over a stream of current/previous pixel pairs.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock in raster order and reports one transfer per
// block, at the block's bottom-right pixel, once that pixel has passed the
// stage-1 and output registers. The changed flags of the block row sit
// in a single-port-per-direction synchronous memory: it is read when a pixel
// transfers and written back from stage 1, and a write is forwarded to the
// read of the next pixel in the same block column. The input only stalls
// while a result waits in the output register and m_tready is low; otherwise
// the rate is one pixel per cycle. There is no clearing pass after reset.
// Configuration writes are meant for idle periods between frames.
// MAX_TILES_ACROSS must be a power of two.
// ----------------------------------------------------------------------------
module dirty_block_detector
    import dbd_pkg::*;
#(
    parameter int MAX_WIDTH        = 2048,
    parameter int MAX_HEIGHT       = 2048,
    parameter int MAX_TILES_ACROSS = 256,
    parameter int PIXEL_BITS       = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [2*PIX_W-1:0]    s_tdata,  // current_pixel, previous_pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [2*IDX_W-1:0]         m_tdata,  // block_col, block_row
    output logic                       m_tuser,  // changed
    output logic                       m_tlast   // last_block
);

    localparam int SLOT_W = $clog2(MAX_TILES_ACROSS);

    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic [BS_W-1:0]       block_size_reg;

    logic                  accept;
    logic                  out_free;
    scan_t                 info;
    logic [SLOT_W-1:0]     slot;
    logic                  res_valid;
    logic [IDX_W-1:0]      res_col, res_row;
    logic                  res_changed, res_last;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [2*IDX_W-1:0]    m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            block_size_reg   <= RST_BLOCK_SIZE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                REG_BLOCK_SIZE:   block_size_reg   <= cfg_wdata[BS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    dbd_scan #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .PIXEL_BITS       (PIXEL_BITS),
        .SLOT_W           (SLOT_W)
    ) u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .current_pixel  (s_tdata[PIX_W-1:0]),
        .previous_pixel (s_tdata[2*PIX_W-1:PIX_W]),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .block_size     (block_size_reg),
        .info           (info),
        .slot           (slot)
    );

    dbd_flags #(
        .DEPTH  (MAX_TILES_ACROSS),
        .SLOT_W (SLOT_W)
    ) u_flags (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .slot        (slot),
        .info        (info),
        .out_free    (out_free),
        .in_ready    (s_tready),
        .res_valid   (res_valid),
        .res_col     (res_col),
        .res_row     (res_row),
        .res_changed (res_changed),
        .res_last    (res_last)
    );

    always_comb begin
        out_free      = !m_tvalid_reg || m_tready;
        m_tvalid_next = m_tvalid_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {res_row, res_col};
            m_tuser_reg <= res_changed;
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

@@ rtl/core/dbd_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbd_scan
// Raster position and block counters; classifies the pixel at the input.
// ----------------------------------------------------------------------------
module dbd_scan
    import dbd_pkg::*;
#(
    parameter int MAX_WIDTH        = 2048,
    parameter int MAX_HEIGHT       = 2048,
    parameter int PIXEL_BITS       = 32,
    parameter int SLOT_W           = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [PIX_W-1:0]      current_pixel,
    input  wire logic [PIX_W-1:0]      previous_pixel,
    input  wire logic [CFG_DATA_W-1:0] image_width,
    input  wire logic [CFG_DATA_W-1:0] image_height,
    input  wire logic [BS_W-1:0]       block_size,
    output scan_t                      info,
    output logic [SLOT_W-1:0]          slot
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int CMP_BITS = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    logic [COL_W-1:0] pixel_col_reg, pixel_col_next;
    logic [ROW_W-1:0] pixel_row_reg, pixel_row_next;
    logic [IDX_W-1:0] tile_col_reg, tile_col_next;
    logic [IDX_W-1:0] tile_row_reg, tile_row_next;
    logic [IDX_W-1:0] col_in_tile_reg, col_in_tile_next;
    logic [IDX_W-1:0] row_in_tile_reg, row_in_tile_next;

    logic [31:0]      w_full, h_full;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [BS_W-1:0]  bs_lim;
    logic [IDX_W-1:0] bs_m1;
    logic             line_end, frame_end, tcol_end, trow_end;

    always_comb begin
        w_full = 32'(image_width);
        h_full = 32'(image_height);
        if (w_full == 32'd0) begin
            w_full = 32'd1;
        end else if (w_full > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end
        if (h_full == 32'd0) begin
            h_full = 32'd1;
        end else if (h_full > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end
        w_m1 = COL_W'(w_full - 32'd1);
        h_m1 = ROW_W'(h_full - 32'd1);

        if (block_size < BS_MIN) begin
            bs_lim = BS_MIN;
        end else if (block_size > BS_MAX) begin
            bs_lim = BS_MAX;
        end else begin
            bs_lim = block_size;
        end
        bs_m1 = IDX_W'(bs_lim - 9'd1);

        line_end  = pixel_col_reg >= w_m1;
        frame_end = pixel_row_reg >= h_m1;
        tcol_end  = line_end || (col_in_tile_reg >= bs_m1);
        trow_end  = frame_end || (row_in_tile_reg >= bs_m1);

        info.report     = tcol_end && trow_end;
        info.last_block = line_end && frame_end;
        info.block_col  = tile_col_reg;
        info.block_row  = tile_row_reg;
        info.differs    = current_pixel[CMP_BITS-1:0] != previous_pixel[CMP_BITS-1:0];
        slot            = SLOT_W'(tile_col_reg);

        pixel_col_next   = pixel_col_reg;
        pixel_row_next   = pixel_row_reg;
        tile_col_next    = tile_col_reg;
        tile_row_next    = tile_row_reg;
        col_in_tile_next = col_in_tile_reg;
        row_in_tile_next = row_in_tile_reg;
        if (line_end) begin
            pixel_col_next   = '0;
            tile_col_next    = '0;
            col_in_tile_next = '0;
            if (frame_end) begin
                pixel_row_next   = '0;
                tile_row_next    = '0;
                row_in_tile_next = '0;
            end else begin
                pixel_row_next = pixel_row_reg + 1'b1;
                if (trow_end) begin
                    row_in_tile_next = '0;
                    tile_row_next    = tile_row_reg + 1'b1;
                end else begin
                    row_in_tile_next = row_in_tile_reg + 1'b1;
                end
            end
        end else begin
            pixel_col_next = pixel_col_reg + 1'b1;
            if (tcol_end) begin
                col_in_tile_next = '0;
                tile_col_next    = tile_col_reg + 1'b1;
            end else begin
                col_in_tile_next = col_in_tile_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_col_reg   <= '0;
            pixel_row_reg   <= '0;
            tile_col_reg    <= '0;
            tile_row_reg    <= '0;
            col_in_tile_reg <= '0;
            row_in_tile_reg <= '0;
        end else if (accept) begin
            pixel_col_reg   <= pixel_col_next;
            pixel_row_reg   <= pixel_row_next;
            tile_col_reg    <= tile_col_next;
            tile_row_reg    <= tile_row_next;
            col_in_tile_reg <= col_in_tile_next;
            row_in_tile_reg <= row_in_tile_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/dbd_flags.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbd_flags
// Changed-flag memory of the block row: read on transfer, update as the pixel
// leaves stage 1, forward the last write to a read of the same column.
// ----------------------------------------------------------------------------
module dbd_flags
    import dbd_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int SLOT_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire scan_t             info,
    input  wire logic              out_free,
    output logic                   in_ready,
    output logic                   res_valid,
    output logic [IDX_W-1:0]       res_col,
    output logic [IDX_W-1:0]       res_row,
    output logic                   res_changed,
    output logic                   res_last
);

    logic              flag_mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;

    logic              s1_valid_reg;
    scan_t             s1_info_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              rd_reg;
    logic              rd_vld_reg;
    logic              fwd_hit_reg;
    logic              fwd_data_reg;

    logic              s1_go;
    logic              old_flag;
    logic              dirty;
    logic              wr_data;

    always_comb begin
        s1_go       = s1_valid_reg && (out_free || !s1_info_reg.report);
        in_ready    = !s1_valid_reg || s1_go;
        old_flag    = fwd_hit_reg ? fwd_data_reg : (rd_reg && rd_vld_reg);
        dirty       = old_flag || s1_info_reg.differs;
        wr_data     = s1_info_reg.report ? 1'b0 : dirty;
        res_valid   = s1_go && s1_info_reg.report;
        res_col     = s1_info_reg.block_col;
        res_row     = s1_info_reg.block_row;
        res_changed = dirty;
        res_last    = s1_info_reg.last_block;
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            flag_mem[s1_slot_reg] <= wr_data;
        end
        if (accept) begin
            rd_reg <= flag_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s1_go) begin
                vld_reg[s1_slot_reg] <= 1'b1;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_go && (s1_slot_reg == slot);
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg  <= info;
            s1_slot_reg  <= slot;
            rd_vld_reg   <= vld_reg[slot];
            fwd_data_reg <= wr_data;
        end
    end

endmodule
`default_nettype wire

@@ sim/dirty_block_detector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_block_detector_test
// Self-checking bench for the dirty block detector.
// ----------------------------------------------------------------------------
// A short table of directed pixels and register writes comes first: reset
// settings, zero and oversized sizes, an unmapped register index, a settings
// change in the middle of a frame and the clipped edge block. Random phases
// follow, each with its own frame size, block size and rate of changed
// pixels, under bursty input and a stalling output. A per-transfer model of
// the block scan predicts block reports, save where a directed row sets its
// own; each report transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module dirty_block_detector_test;
    import dbd_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 2048;
    localparam int RANDOM_ITEMS  = 600;
    localparam int EXTREME_ITEMS = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int NUM_DIRECTED  = 27;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] block_col;
        logic [IDX_W-1:0] block_row;
        logic             changed;
        logic             last_block;
    } block_report_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_BLOCK} exp_mode_e;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_style_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        logic [PIX_W-1:0]      cur;
        logic [PIX_W-1:0]      prev;
        exp_mode_e             mode;
        block_report_t         want;
    } row_t;

    localparam block_report_t NO_REPORT = '0;

    localparam row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0000, 32'h0000_0000, EXP_NONE, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'hFFFF_FFFF, 32'h0000_0000, EXP_NONE, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0000, 32'hFFFF_FFFF, EXP_PREDICT, NO_REPORT},
        '{ROW_WRITE, REG_SPARE, 12'hFFF, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_WRITE, REG_IMAGE_WIDTH, 12'd0, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_WRITE, REG_IMAGE_HEIGHT, 12'd0, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_WRITE, REG_BLOCK_SIZE, 12'd0, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0000, 32'h0000_0000, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h8000_0000, 32'h0000_0000, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0001, 32'h0000_0000, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h1234_5678, 32'h1234_5678, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b0, 1'b1}},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b0, 1'b1}},
        '{ROW_WRITE, REG_IMAGE_WIDTH, 12'd2, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_WRITE, REG_BLOCK_SIZE, 12'd511, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0000, 32'h0000_0001, EXP_NONE, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0005, 32'h0000_0005, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b1, 1'b1}},
        '{ROW_WRITE, REG_IMAGE_WIDTH, 12'd9, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_WRITE, REG_BLOCK_SIZE, 12'd8, 32'h0, 32'h0, EXP_NONE, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0001, 32'h0000_0000, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'hA5A5_A5A5, 32'hA5A5_A5A5, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h5A5A_5A5A, 32'h5A5A_5A5A, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0000, 32'h0000_0000, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0F0F_0F0F, 32'h0F0F_0F0F, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h7777_7777, 32'h7777_7777, EXP_PREDICT, NO_REPORT},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'h0000_0000, 32'h0000_0000, EXP_BLOCK,
          '{8'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_PIXEL, REG_SPARE, 12'h0, 32'hFFFF_0000, 32'h0000_FFFF, EXP_BLOCK,
          '{8'd1, 8'd0, 1'b1, 1'b1}}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [2*PIX_W-1:0]    s_tdata   = '0;   // current_pixel, previous_pixel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*IDX_W-1:0]    m_tdata;          // block_col, block_row
    logic                  m_tuser;          // changed
    logic                  m_tlast;          // last_block

    dirty_block_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // scan model: settings and position of the next pixel
    logic [CFG_DATA_W-1:0] width_reg  = RST_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] height_reg = RST_IMAGE_HEIGHT;
    logic [BS_W-1:0]       bsize_reg  = RST_BLOCK_SIZE;
    logic [10:0]           pos_col    = '0;
    logic [10:0]           pos_row    = '0;
    logic [IDX_W-1:0]      blk_col    = '0;
    logic [IDX_W-1:0]      blk_row    = '0;
    logic [IDX_W-1:0]      off_col    = '0;
    logic [IDX_W-1:0]      off_row    = '0;
    bit                    dirty_flags [256];

    block_report_t pending_reports [$];
    exp_mode_e     row_mode = EXP_PREDICT;
    block_report_t row_want = NO_REPORT;

    int mismatches      = 0;
    int pixels_seen     = 0;
    int reports_seen    = 0;
    int changed_seen    = 0;
    int settings_seen   = 0;
    int quiet_cycles    = 0;
    int burst_left      = 0;
    int gap_left        = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit scan_pixel(input logic [PIX_W-1:0] cur,
                                      input logic [PIX_W-1:0] prev,
                                      output block_report_t rep);
        int unsigned w, h, bs;
        bit line_end, frame_end, col_end, row_end, done;
        w         = clip(width_reg, 1, MAX_W);
        h         = clip(height_reg, 1, MAX_H);
        bs        = clip(bsize_reg, BS_MIN, BS_MAX);
        line_end  = pos_col >= w - 1;
        frame_end = pos_row >= h - 1;
        col_end   = line_end || off_col >= bs - 1;
        row_end   = frame_end || off_row >= bs - 1;
        done      = col_end && row_end;
        if (cur != prev) dirty_flags[blk_col] = 1'b1;
        rep = '{blk_col, blk_row, dirty_flags[blk_col], line_end && frame_end};
        if (done) dirty_flags[blk_col] = 1'b0;
        if (line_end) begin
            pos_col = '0;
            blk_col = '0;
            off_col = '0;
            if (frame_end) begin
                pos_row = '0;
                blk_row = '0;
                off_row = '0;
            end else begin
                pos_row = pos_row + 1'b1;
                if (row_end) begin
                    off_row = '0;
                    blk_row = blk_row + 1'b1;
                end else begin
                    off_row = off_row + 1'b1;
                end
            end
        end else begin
            pos_col = pos_col + 1'b1;
            if (col_end) begin
                off_col = '0;
                blk_col = blk_col + 1'b1;
            end else begin
                off_col = off_col + 1'b1;
            end
        end
        return done;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_report();
        block_report_t want;
        reports_seen++;
        if (m_tuser === 1'b1) changed_seen++;
        if (pending_reports.size() == 0) begin
            $error("block report col %0d row %0d with none expected",
                   m_tdata[IDX_W-1:0], m_tdata[2*IDX_W-1:IDX_W]);
            mismatches++;
        end else begin
            want = pending_reports.pop_front();
            compare_field("block_col", want.block_col, m_tdata[IDX_W-1:0]);
            compare_field("block_row", want.block_row, m_tdata[2*IDX_W-1:IDX_W]);
            compare_field("changed", want.changed, m_tuser);
            compare_field("last_block", want.last_block, m_tlast);
        end
    endtask

    task automatic take_pixel();
        block_report_t rep;
        bit            done;
        done = scan_pixel(s_tdata[PIX_W-1:0], s_tdata[2*PIX_W-1:PIX_W], rep);
        case (row_mode)
            EXP_PREDICT: if (done) pending_reports.push_back(rep);
            EXP_BLOCK:   pending_reports.push_back(row_want);
            default: ;
        endcase
        pixels_seen++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready) check_report();
            if (s_tvalid && s_tready === 1'b1) take_pixel();
            if ((m_tvalid === 1'b1 && m_tready) || (s_tvalid && s_tready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin : receiver
        rx_style_e style;
        int        left;
        style = RX_OPEN;
        left  = 0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                style = rx_style_e'($urandom_range(2, 0));
                left  = $urandom_range(120, 10);
            end
            left--;
            case (style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(9, 0) < 6);
                default:   m_tready <= ($urandom_range(9, 0) == 0);
            endcase
        end
    end

    initial begin : watchdog
        wait (aresetn === 1'b1);
        while (quiet_cycles < QUIET_LIMIT) @(negedge aclk);
        $error("no transfer for %0d cycles", QUIET_LIMIT);
        $display("dirty_block_detector verification failed");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] prev,
                              input exp_mode_e mode, input block_report_t want);
        if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
            gap_left = 0;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prev, cur};
        row_mode <= mode;
        row_want <= want;
        do @(posedge aclk); while (s_tready !== 1'b1);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                     : $urandom_range(40, 1);
            gap_left   = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
        end
    endtask

    // drop valid and hold until every expected report has arrived
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            REG_IMAGE_WIDTH:  width_reg  = data;
            REG_IMAGE_HEIGHT: height_reg = data;
            REG_BLOCK_SIZE:   bsize_reg  = data[BS_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w_raw,
                             input logic [CFG_DATA_W-1:0] h_raw,
                             input logic [CFG_DATA_W-1:0] bs_raw,
                             input int count, input int rate);
        logic [PIX_W-1:0] cur, prev, flip;
        settle();
        write_register(REG_IMAGE_WIDTH, w_raw);
        write_register(REG_IMAGE_HEIGHT, h_raw);
        write_register(REG_BLOCK_SIZE, bs_raw);
        if ($urandom_range(3, 0) == 0)
            write_register(REG_SPARE, CFG_DATA_W'($urandom_range(4095, 0)));
        settings_seen++;
        for (int k = 0; k < count; k++) begin
            prev = $urandom;
            cur  = prev;
            if ($urandom_range(999, 0) < rate) begin
                flip = $urandom_range(1, 0) ? (32'h1 << $urandom_range(31, 0))
                                            : ($urandom | 32'h1);
                cur  = prev ^ flip;
            end
            if ($urandom_range(299, 0) == 0) hold_until_drained();
            send_pixel(cur, prev, EXP_PREDICT, NO_REPORT);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        int r;
        r = $urandom_range(19, 0);
        if (r == 0) return '0;
        if (r < 3) return CFG_DATA_W'($urandom_range(3, 1));
        if (r < 5) return CFG_DATA_W'($urandom_range(64, 25));
        return CFG_DATA_W'($urandom_range(24, 4));
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] w_raw, h_raw, bs_raw;
        int                    area, count, rate, random_items;
        random_items = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            if (DIRECTED[k].kind == ROW_WRITE) begin
                settle();
                write_register(DIRECTED[k].addr, DIRECTED[k].wdata);
            end else begin
                send_pixel(DIRECTED[k].cur, DIRECTED[k].prev, DIRECTED[k].mode,
                           DIRECTED[k].want);
            end
        end
        settings_seen = 4;

        // widest line with the smallest blocks, then the tallest column
        run_phase(12'd4095, 12'd1, 12'd8, EXTREME_ITEMS, 40);
        run_phase(12'd1, 12'd4095, 12'd7, EXTREME_ITEMS, 40);

        while (random_items < RANDOM_ITEMS) begin
            w_raw = pick_extent();
            h_raw = pick_extent();
            case ($urandom_range(9, 0))
                0:       bs_raw = CFG_DATA_W'($urandom_range(7, 0));
                1:       bs_raw = CFG_DATA_W'($urandom_range(511, 257));
                2:       bs_raw = CFG_DATA_W'($urandom_range(64, 17));
                default: bs_raw = CFG_DATA_W'($urandom_range(16, 8));
            endcase
            area = clip(w_raw, 1, MAX_W) * clip(h_raw, 1, MAX_H);
            if (area > 800)
                count = $urandom_range(area, area / 4);
            else if ($urandom_range(4, 0) == 0)
                count = $urandom_range(area * 2, 1);
            else
                count = area * $urandom_range(3, 1);
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            case ($urandom_range(3, 0))
                0:       rate = 0;
                1:       rate = 5;
                2:       rate = 40;
                default: rate = 400;
            endcase
            run_phase(w_raw, h_raw, bs_raw, count, rate);
            random_items += count;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d pixel transfers over %0d size settings, zero, oversized and",
                 pixels_seen, settings_seen);
        $display("out-of-range sizes among them; %0d block reports, %0d changed, %0d mismatches",
                 reports_seen, changed_seen, mismatches);
        if (mismatches == 0) begin
            $display("dirty_block_detector verification clean");
        end else begin
            $display("dirty_block_detector verification failed");
        end
        $finish;
    end

endmodule
